[rtl/core/sorted_insert_priority_queue_assert.svh]
// assertion shorthands for the queue checker, clocked on clk, off while arst_n is low
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// consequent checked in the same cycle
`define SIPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SIPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sipq_pkg.sv]
`default_nettype none
package sipq_pkg;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [30:0] id;
		logic [15:0] key;
	} entry_t;

	typedef struct packed {
		logic        action;
		logic [30:0] item_id;
		logic [15:0] item_key;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [30:0] out_id;
		logic [15:0] out_key;
		logic [6:0]  occupancy;
	} rsp_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_INS_CMP,
		SQ_INS_WR,
		SQ_POP_HEAD,
		SQ_POP_MOVE,
		SQ_RESP
	} state_t;

endpackage
`default_nettype wire

[rtl/core/sipq_stream_if.sv]
`default_nettype none
interface sipq_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/sipq_ram.sv]
`default_nettype none
module sipq_ram #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  sipq_pkg::entry_t    wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output sipq_pkg::entry_t    rd_data
);

	sipq_pkg::entry_t mem_q [DEPTH];
	sipq_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[rtl/core/sorted_insert_priority_queue.sv]
// channel | dir | payload                              | transaction
// req     | in  | action, item_id, item_key            | req.valid && req.ready
// rsp     | out | status, out_id, out_key, occupancy   | rsp.valid && rsp.ready
//
// one operation at a time; req.ready is high only while the sequencer is idle
// insert: each entry with a larger key moves back one place, then the item is written
// pop: the head is taken, later entries move up; full insert or empty pop move nothing
// the single-port-read entry ram moves one entry per cycle
// arst_n clears fill count, sequencer and rsp.valid; entry ram contents are not cleared
// a result held by a stalled rsp blocks only the delivery of the next one
`default_nettype none
module sorted_insert_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	sipq_stream_if.sink   req,
	sipq_stream_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] TWO = CW'(2);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	sipq_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     fill_q, fill_d;
	logic [CW-1:0]     pos_q, pos_d;
	logic [CW-1:0]     fill_m1, pos_m1, pos_m2, pos_p1;
	sipq_pkg::entry_t  new_q;
	sipq_pkg::status_t res_status_q, res_status_d;
	sipq_pkg::entry_t  res_entry_q, res_entry_d;
	logic              rsp_valid_q;
	sipq_pkg::rsp_t    rsp_data_q;
	logic [CW+6:0]     occ_ext;
	logic              req_ready;
	logic              load_out;

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	sipq_pkg::entry_t  wr_data, rd_data;

	sipq_ram #(.DEPTH(CAPACITY)) u_sipq_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign fill_m1 = fill_q - ONE;
	assign pos_m1  = pos_q - ONE;
	assign pos_m2  = pos_q - TWO;
	assign pos_p1  = pos_q + ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sipq_pkg::SQ_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		res_status_q <= res_status_d;
		res_entry_q  <= res_entry_d;
		if (req.valid && req_ready) begin
			new_q.id  <= req.data.item_id;
			new_q.key <= req.data.item_key;
		end
	end

	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		pos_d        = pos_q;
		res_status_d = res_status_q;
		res_entry_d  = res_entry_q;
		wr_en        = 1'b0;
		wr_addr      = pos_q[AW-1:0];
		wr_data      = new_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		req_ready    = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			sipq_pkg::SQ_IDLE: begin
				req_ready   = 1'b1;
				res_entry_d = '0;
				if (req.valid) begin
					if (req.data.action == sipq_pkg::ACT_INSERT) begin
						if (fill_q == CAP) begin
							res_status_d = sipq_pkg::ST_FULL;
							state_d      = sipq_pkg::SQ_RESP;
						end else begin
							res_status_d = sipq_pkg::ST_INSERTED;
							pos_d        = fill_q;
							if (fill_q == '0) begin
								state_d = sipq_pkg::SQ_INS_WR;
							end else begin
								rd_en   = 1'b1;
								rd_addr = fill_m1[AW-1:0];
								state_d = sipq_pkg::SQ_INS_CMP;
							end
						end
					end else begin
						if (fill_q == '0) begin
							res_status_d = sipq_pkg::ST_EMPTY;
							state_d      = sipq_pkg::SQ_RESP;
						end else begin
							res_status_d = sipq_pkg::ST_POPPED;
							rd_en        = 1'b1;
							rd_addr      = '0;
							pos_d        = ONE;
							state_d      = sipq_pkg::SQ_POP_HEAD;
						end
					end
				end
			end
			sipq_pkg::SQ_INS_CMP: begin
				// rd_data holds the entry just below pos_q
				wr_en = 1'b1;
				if (rd_data.key > new_q.key) begin
					wr_data = rd_data;
					pos_d   = pos_m1;
					if (pos_m1 != '0) begin
						rd_en   = 1'b1;
						rd_addr = pos_m2[AW-1:0];
					end else begin
						state_d = sipq_pkg::SQ_INS_WR;
					end
				end else begin
					fill_d  = fill_q + ONE;
					state_d = sipq_pkg::SQ_RESP;
				end
			end
			sipq_pkg::SQ_INS_WR: begin
				wr_en   = 1'b1;
				fill_d  = fill_q + ONE;
				state_d = sipq_pkg::SQ_RESP;
			end
			sipq_pkg::SQ_POP_HEAD: begin
				res_entry_d = rd_data;
				if (pos_q < fill_q) begin
					rd_en   = 1'b1;
					rd_addr = pos_q[AW-1:0];
					state_d = sipq_pkg::SQ_POP_MOVE;
				end else begin
					fill_d  = fill_m1;
					state_d = sipq_pkg::SQ_RESP;
				end
			end
			sipq_pkg::SQ_POP_MOVE: begin
				// move entry pos_q up one place while the next one is read
				wr_en   = 1'b1;
				wr_addr = pos_m1[AW-1:0];
				wr_data = rd_data;
				pos_d   = pos_p1;
				if (pos_p1 < fill_q) begin
					rd_en   = 1'b1;
					rd_addr = pos_p1[AW-1:0];
				end else begin
					fill_d  = fill_m1;
					state_d = sipq_pkg::SQ_RESP;
				end
			end
			sipq_pkg::SQ_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = sipq_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = sipq_pkg::SQ_IDLE;
			end
		endcase
	end

	assign occ_ext = {7'd0, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_data_q.status    <= res_status_q;
			rsp_data_q.out_id    <= res_entry_q.id;
			rsp_data_q.out_key   <= res_entry_q.key;
			rsp_data_q.occupancy <= occ_ext[6:0];
		end
	end

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule
`default_nettype wire

[rtl/core/sipq_checker.sv]
`default_nettype none
`include "sorted_insert_priority_queue_assert.svh"
module sipq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sipq_pkg::rsp_t rsp_data
);

	// one operation in flight: ready drops right after a transaction
	`SIPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

	`SIPQ_ASSERT_NOW(a_zero_payload, rsp_valid && rsp_data.status != sipq_pkg::ST_POPPED, rsp_data.out_id == 31'd0 && rsp_data.out_key == 16'd0, "nonzero id or key without pop")

	`SIPQ_ASSERT_NOW(a_empty_occupancy, rsp_valid && rsp_data.status == sipq_pkg::ST_EMPTY, rsp_data.occupancy == 7'd0, "empty pop with nonzero occupancy")

	`SIPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire
